>>> rtl/core/utf8_name_validator_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the name validator RTL
// ---------------------------------------------------------------------------
`ifndef UTF8_NAME_VALIDATOR_MACROS_SVH
`define UTF8_NAME_VALIDATOR_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define UNV_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
        else $error("unv assertion failed");

// When the antecedent holds, the consequent must hold in the next cycle.
`define UNV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("unv assertion failed");

`endif

>>> rtl/core/unv_pkg.sv
// ---------------------------------------------------------------------------
// unv_pkg
// Shared types and constants of the UTF-8 object name validator.
// ---------------------------------------------------------------------------
package unv_pkg;

    localparam int MAX_NAME_LEN_DEF = 256;
    localparam int LEN_W            = 9;
    localparam int QUEUE_DEPTH_DEF  = 2;

    // Result codes; the scan error register uses the same encoding.
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_BAD  = 2'd1;
    localparam logic [1:0] ST_LONG = 2'd2;

    // Allowed range of the next continuation byte.
    localparam logic [2:0] LC_ANY = 3'd0;  // 80-BF
    localparam logic [2:0] LC_E0  = 3'd1;  // A0-BF
    localparam logic [2:0] LC_ED  = 3'd2;  // 80-9F
    localparam logic [2:0] LC_F0  = 3'd3;  // 90-BF
    localparam logic [2:0] LC_F4  = 3'd4;  // 80-8F

    // Classification of one byte, produced by the front and consumed by the back.
    typedef struct packed {
        logic       is_term;
        logic       classic;
        logic       is_slash;
        logic       classic_bad;
        logic       ascii;
        logic       first_ok;
        logic       ctrl;
        logic       is_space;
        logic       lead_bad;
        logic [1:0] lead_cont;
        logic [2:0] lead_class;
        logic       in_80_bf;
        logic       in_a0_bf;
        logic       in_80_9f;
        logic       in_90_bf;
        logic       in_80_8f;
    } t_cls;

endpackage

>>> rtl/core/unv_front.sv
// ---------------------------------------------------------------------------
// unv_front
// Holds the rule-set register and classifies each accepted byte.
// ---------------------------------------------------------------------------
module unv_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_wdata,
    input  logic              i_push,
    input  logic [7:0]        i_byte_value,
    input  logic              i_q_full,
    output logic              o_q_push,
    output unv_pkg::t_cls     o_cls
);

    logic       r_classic;
    logic [7:0] b;
    logic       alnum;
    logic       classic_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_classic <= 1'b0;
        end else if (i_cfg_we) begin
            r_classic <= i_cfg_wdata;
        end
    end

    assign b        = i_byte_value;
    assign o_q_push = i_push & ~i_q_full;

    always_comb begin
        alnum = (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A) ||
                (b >= 8'h30 && b <= 8'h39);
        classic_ok = alnum || b == 8'h5F || b == 8'h2D || b == 8'h2B ||
                     b == 8'h2E || b == 8'h3A || b == 8'h40 || b == 8'h28 ||
                     b == 8'h29;

        o_cls             = '0;
        o_cls.is_term     = (b == 8'h00);
        o_cls.classic     = r_classic;
        o_cls.is_slash    = (b == 8'h2F);
        o_cls.classic_bad = r_classic & ~classic_ok;
        o_cls.ascii       = ~b[7];
        o_cls.first_ok    = alnum || b == 8'h5F;
        o_cls.ctrl        = (b < 8'h20) || (b > 8'h7E);
        o_cls.is_space    = (b == 8'h20);
        o_cls.in_80_bf    = (b[7:6] == 2'b10);
        o_cls.in_a0_bf    = (b >= 8'hA0 && b <= 8'hBF);
        o_cls.in_80_9f    = (b >= 8'h80 && b <= 8'h9F);
        o_cls.in_90_bf    = (b >= 8'h90 && b <= 8'hBF);
        o_cls.in_80_8f    = (b >= 8'h80 && b <= 8'h8F);

        // Lead byte decode; stray continuations and overlong or
        // out-of-range leads are flagged as bad.
        if (b >= 8'hC2 && b <= 8'hDF) begin
            o_cls.lead_cont = 2'd1;
        end else if (b == 8'hE0) begin
            o_cls.lead_cont  = 2'd2;
            o_cls.lead_class = unv_pkg::LC_E0;
        end else if (b == 8'hED) begin
            o_cls.lead_cont  = 2'd2;
            o_cls.lead_class = unv_pkg::LC_ED;
        end else if (b >= 8'hE1 && b <= 8'hEF) begin
            o_cls.lead_cont = 2'd2;
        end else if (b == 8'hF0) begin
            o_cls.lead_cont  = 2'd3;
            o_cls.lead_class = unv_pkg::LC_F0;
        end else if (b >= 8'hF1 && b <= 8'hF3) begin
            o_cls.lead_cont = 2'd3;
        end else if (b == 8'hF4) begin
            o_cls.lead_cont  = 2'd3;
            o_cls.lead_class = unv_pkg::LC_F4;
        end else if (b[7]) begin
            o_cls.lead_bad = 1'b1;
        end
    end

endmodule

>>> rtl/core/unv_queue.sv
// ---------------------------------------------------------------------------
// unv_queue
// Small register queue that decouples byte classification from checking.
// ---------------------------------------------------------------------------
module unv_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = unv_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & ~o_empty;
    assign o_rdata = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

endmodule

>>> rtl/core/unv_back.sv
// ---------------------------------------------------------------------------
// unv_back
// Tracks UTF-8 sequence state and name rules; emits the status beat.
// ---------------------------------------------------------------------------
`include "utf8_name_validator_macros.svh"

module unv_back #(
    parameter int MAX_NAME_LEN = unv_pkg::MAX_NAME_LEN_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  unv_pkg::t_cls i_cls,
    output logic          o_q_pop,
    output logic          o_empty,
    input  logic          i_pop,
    output logic [1:0]    o_status
);

    localparam logic [unv_pkg::LEN_W-1:0] LEN_MAX = unv_pkg::LEN_W'(MAX_NAME_LEN);

    logic [unv_pkg::LEN_W-1:0] r_len, n_len;
    logic [1:0]                r_cont, n_cont;
    logic [2:0]                r_lclass, n_lclass;
    logic                      r_first, n_first;
    logic                      r_gbad, n_gbad;
    logic [1:0]                r_scan, n_scan;
    logic                      r_space, n_space;
    logic                      r_out_valid;
    logic [1:0]                r_out_status;

    logic       go;
    logic       overflow;
    logic       consumed;
    logic       range_ok;
    logic [1:0] term_status;

    // A terminator needs a free output slot; other bytes never stall.
    assign go       = i_q_valid & (~i_cls.is_term | ~r_out_valid | i_pop);
    assign o_q_pop  = go;
    assign o_empty  = ~r_out_valid;
    assign o_status = r_out_status;
    assign overflow = (r_len >= LEN_MAX);

    always_comb begin
        case (r_lclass)
            unv_pkg::LC_E0: range_ok = i_cls.in_a0_bf;
            unv_pkg::LC_ED: range_ok = i_cls.in_80_9f;
            unv_pkg::LC_F0: range_ok = i_cls.in_90_bf;
            unv_pkg::LC_F4: range_ok = i_cls.in_80_8f;
            default:        range_ok = i_cls.in_80_bf;
        endcase
    end

    always_comb begin
        if (r_len == '0 || r_cont != 2'd0 || r_gbad) begin
            term_status = unv_pkg::ST_BAD;
        end else if (r_scan != unv_pkg::ST_OK) begin
            term_status = r_scan;
        end else if (r_space) begin
            term_status = unv_pkg::ST_BAD;
        end else begin
            term_status = unv_pkg::ST_OK;
        end
    end

    always_comb begin
        n_len    = r_len;
        n_cont   = r_cont;
        n_lclass = r_lclass;
        n_first  = r_first;
        n_gbad   = r_gbad;
        n_scan   = r_scan;
        n_space  = r_space;
        consumed = 1'b0;

        if (i_cls.is_term) begin
            n_len    = '0;
            n_cont   = 2'd0;
            n_lclass = unv_pkg::LC_ANY;
            n_first  = 1'b1;
            n_gbad   = 1'b0;
            n_scan   = unv_pkg::ST_OK;
            n_space  = 1'b0;
        end else begin
            if (!overflow) begin
                n_len = r_len + 1'b1;
            end
            if (i_cls.is_slash || i_cls.classic_bad) begin
                n_gbad = 1'b1;
            end

            if (r_cont != 2'd0) begin
                n_lclass = unv_pkg::LC_ANY;
                if (range_ok) begin
                    n_cont   = r_cont - 1'b1;
                    consumed = 1'b1;
                end else begin
                    // Broken sequence: this byte is re-examined as a new character.
                    n_gbad = 1'b1;
                    n_cont = 2'd0;
                end
            end

            if (!consumed) begin
                if (!i_cls.ascii) begin
                    if (i_cls.lead_bad) begin
                        n_gbad = 1'b1;
                    end else begin
                        n_cont   = i_cls.lead_cont;
                        n_lclass = i_cls.lead_class;
                    end
                end
                if (!i_cls.classic && i_cls.ascii) begin
                    if ((r_first && !i_cls.first_ok) || (!r_first && i_cls.ctrl)) begin
                        if (n_scan == unv_pkg::ST_OK) begin
                            n_scan = unv_pkg::ST_BAD;
                        end
                    end
                end
                n_space = i_cls.is_space;
                n_first = 1'b0;
            end

            if (overflow && n_scan == unv_pkg::ST_OK) begin
                n_scan = unv_pkg::ST_LONG;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_cont      <= 2'd0;
            r_lclass    <= unv_pkg::LC_ANY;
            r_first     <= 1'b1;
            r_gbad      <= 1'b0;
            r_scan      <= unv_pkg::ST_OK;
            r_space     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (go) begin
                r_len    <= n_len;
                r_cont   <= n_cont;
                r_lclass <= n_lclass;
                r_first  <= n_first;
                r_gbad   <= n_gbad;
                r_scan   <= n_scan;
                r_space  <= n_space;
            end
            if (go && i_cls.is_term) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (go && i_cls.is_term) begin
            r_out_status <= term_status;
        end
    end

    `UNV_ASSERT_ALWAYS(a_len_bound, i_clk, i_rst_n, r_len <= LEN_MAX)
    `UNV_ASSERT_ALWAYS(a_class_needs_cont, i_clk, i_rst_n,
        r_cont != 2'd0 || r_lclass == unv_pkg::LC_ANY)
    `UNV_ASSERT_NEXT(a_term_clears, i_clk, i_rst_n, go && i_cls.is_term,
        r_out_valid && r_len == '0 && r_first && !r_gbad && r_scan == unv_pkg::ST_OK)
    `UNV_ASSERT_ALWAYS(a_scan_code, i_clk, i_rst_n,
        r_scan == unv_pkg::ST_OK || r_scan == unv_pkg::ST_BAD || r_scan == unv_pkg::ST_LONG)

endmodule

>>> rtl/core/utf8_name_validator.sv
// ---------------------------------------------------------------------------
// utf8_name_validator
// Streaming checker for object names encoded as UTF-8.
// ---------------------------------------------------------------------------
// Bytes enter through a queue-style port: a beat is taken when i_push is high
// and o_full is low. A zero byte ends the name and produces one status beat;
// other bytes produce none. The status waits on o_status while o_empty is low
// and is taken by i_pop. Status: 0 valid, 1 bad name, 2 name too long.
// i_cfg_we writes i_cfg_wdata into the classic rule-set bit; write it only
// while no name is in flight.
// Each byte is classified in the front, passes a two-entry queue and is
// checked in the back, one byte per cycle. A terminator passes the queue
// and the status register before its status can be popped. Throughput is
// one byte per cycle; the back stalls only on a terminator while the previous
// status has not been popped, and the queue then fills and raises o_full.
// Synchronous reset empties the queue, drops any pending status, clears the
// name state and selects the extended rules.
// ---------------------------------------------------------------------------
module utf8_name_validator #(
    parameter int MAX_NAME_LEN = unv_pkg::MAX_NAME_LEN_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    input  logic       i_push,
    output logic       o_full,
    input  logic [7:0] i_byte_value,
    output logic       o_empty,
    input  logic       i_pop,
    output logic [1:0] o_status
);

    localparam int CLS_W = $bits(unv_pkg::t_cls);

    unv_pkg::t_cls f_cls;
    unv_pkg::t_cls q_cls;
    logic          q_push;
    logic          q_full;
    logic          q_empty;
    logic          q_pop;

    assign o_full = q_full;

    unv_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_push       (i_push),
        .i_byte_value (i_byte_value),
        .i_q_full     (q_full),
        .o_q_push     (q_push),
        .o_cls        (f_cls)
    );

    unv_queue #(
        .WIDTH (CLS_W),
        .DEPTH (unv_pkg::QUEUE_DEPTH_DEF)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_wdata (f_cls),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_rdata (q_cls),
        .o_empty (q_empty)
    );

    unv_back #(
        .MAX_NAME_LEN (MAX_NAME_LEN)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (~q_empty),
        .i_cls     (q_cls),
        .o_q_pop   (q_pop),
        .o_empty   (o_empty),
        .i_pop     (i_pop),
        .o_status  (o_status)
    );

endmodule

>>> test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the UTF-8 object name validator
// Streams names into the byte port. The directed table or a built-in model
// gives each expected status beat. Directed names come first, then random
// names with random idles on both ports and rule-set changes between phases.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int NAME_LIMIT   = unv_pkg::MAX_NAME_LEN_DEF;
    localparam int FROM_MODEL   = -1;
    localparam int DRAIN_CYCLES = 6;
    localparam int RANDOM_BYTES = 310;
    localparam int CYCLE_LIMIT  = 200000;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_A     = 8'h61;
    localparam logic [7:0] CH_DEL   = 8'h7F;
    localparam logic [63:0] PUNCT   = "_-+.:@()";

    logic       i_clk        = 1'b0;
    logic       i_rst_n      = 1'b0;
    logic       i_cfg_we     = 1'b0;
    logic       i_cfg_wdata  = 1'b0;
    logic       i_push       = 1'b0;
    logic [7:0] i_byte_value = 8'h00;
    logic       i_pop        = 1'b0;
    logic       o_full;
    logic       o_empty;
    logic [1:0] o_status;

    // Model state of the name being scanned.
    int         name_len;
    logic [1:0] cont_left;
    logic [2:0] cont_range;
    bit         first_pending;
    bit         name_broken;
    logic [1:0] first_fault;
    bit         trailing_space;
    bit         classic_mode;

    logic [1:0] status_due[$];
    logic [1:0] status_want;
    bit         calm = 1'b0;
    int         failures    = 0;
    int         beats_seen  = 0;
    int         bytes_sent  = 0;
    int         mode_writes = 0;
    int         long_names  = 0;
    int         cycles      = 0;

    typedef struct packed {
        bit          mode;
        int          fill;
        int          nb;
        logic [63:0] seq;
        bit          term;
        int          want;
    } t_name_row;

    // Row: rule set, leading 'a' bytes, byte count, bytes, terminator, expected status.
    t_name_row directed_names [0:29] = '{
        '{1'b0, 0,   0, 64'h0,                1'b1, unv_pkg::ST_BAD},
        '{1'b0, 0,   1, 64'h61,               1'b1, unv_pkg::ST_OK},
        '{1'b0, 0,   3, 64'h612F62,           1'b1, unv_pkg::ST_BAD},
        '{1'b0, 0,   2, 64'h2D61,             1'b1, unv_pkg::ST_BAD},
        '{1'b0, 0,   2, 64'h5F20,             1'b1, unv_pkg::ST_BAD},
        '{1'b0, 0,   4, 64'h6120627E,         1'b1, unv_pkg::ST_OK},
        '{1'b0, 0,   2, 64'h617F,             1'b1, unv_pkg::ST_BAD},
        '{1'b0, 0,   2, 64'h6101,             1'b1, unv_pkg::ST_BAD},
        '{1'b0, 0,   4, 64'hC280DFBF,         1'b1, FROM_MODEL},
        '{1'b0, 0,   6, 64'hE0A080ED9FBF,     1'b1, FROM_MODEL},
        '{1'b0, 0,   8, 64'hF0908080F48FBFBF, 1'b1, FROM_MODEL},
        '{1'b0, 0,   6, 64'hF1808080C3A9,     1'b1, FROM_MODEL},
        '{1'b0, 0,   3, 64'hE09F80,           1'b1, FROM_MODEL},
        '{1'b0, 0,   3, 64'hEDA080,           1'b1, FROM_MODEL},
        '{1'b0, 0,   4, 64'hF08F8080,         1'b1, FROM_MODEL},
        '{1'b0, 0,   4, 64'hF4908080,         1'b1, FROM_MODEL},
        '{1'b0, 0,   2, 64'h6180,             1'b1, unv_pkg::ST_BAD},
        '{1'b0, 0,   1, 64'hC1,               1'b1, unv_pkg::ST_BAD},
        '{1'b0, 0,   3, 64'h61F5FF,           1'b1, unv_pkg::ST_BAD},
        '{1'b0, 0,   3, 64'h61E180,           1'b1, unv_pkg::ST_BAD},
        '{1'b0, 0,   3, 64'hC34162,           1'b1, unv_pkg::ST_BAD},
        '{1'b0, 256, 0, 64'h0,                1'b1, unv_pkg::ST_OK},
        '{1'b0, 257, 0, 64'h0,                1'b1, unv_pkg::ST_LONG},
        '{1'b0, 256, 1, 64'h01,               1'b1, unv_pkg::ST_BAD},
        '{1'b1, 0,   6, 64'h6140285A3929,     1'b1, unv_pkg::ST_OK},
        '{1'b1, 0,   2, 64'h2D2E,             1'b1, unv_pkg::ST_OK},
        '{1'b1, 0,   3, 64'h612062,           1'b1, unv_pkg::ST_BAD},
        '{1'b1, 0,   2, 64'hC3A9,             1'b1, unv_pkg::ST_BAD},
        '{1'b1, 256, 1, 64'h21,               1'b1, unv_pkg::ST_BAD},
        // The rule set flips in the middle of the next two names.
        '{1'b1, 0,   1, 64'h61,               1'b0, FROM_MODEL}
    };
    t_name_row split_tail [0:2] = '{
        '{1'b0, 0,   1, 64'h20,               1'b1, FROM_MODEL},
        '{1'b0, 0,   1, 64'h7E,               1'b0, FROM_MODEL},
        '{1'b1, 0,   1, 64'h62,               1'b1, FROM_MODEL}
    };

    utf8_name_validator #(
        .MAX_NAME_LEN (NAME_LIMIT)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_push       (i_push),
        .o_full       (o_full),
        .i_byte_value (i_byte_value),
        .o_empty      (o_empty),
        .i_pop        (i_pop),
        .o_status     (o_status)
    );

    always #10 i_clk = ~i_clk;

    function automatic bit is_alnum(input logic [7:0] b);
        return (b >= "A" && b <= "Z") || (b >= "a" && b <= "z") || (b >= "0" && b <= "9");
    endfunction

    function automatic bit in_classic_set(input logic [7:0] b);
        return is_alnum(b) || b == "_" || b == "-" || b == "+" || b == "." ||
               b == ":" || b == "@" || b == "(" || b == ")";
    endfunction

    function automatic void clear_name_state();
        name_len       = 0;
        cont_left      = 2'd0;
        cont_range     = unv_pkg::LC_ANY;
        first_pending  = 1'b1;
        name_broken    = 1'b0;
        first_fault    = unv_pkg::ST_OK;
        trailing_space = 1'b0;
    endfunction

    function automatic void note_fault(input logic [1:0] code);
        if (first_fault == unv_pkg::ST_OK) begin
            first_fault = code;
        end
    endfunction

    // Advances the name scan by one byte; returns 1 with the status on a terminator.
    function automatic bit scan_name_byte(input logic [7:0] b, output logic [1:0] st);
        bit over;
        bit used;
        bit plain;
        logic [7:0] lo;
        logic [7:0] hi;
        st = unv_pkg::ST_OK;
        if (b == CH_NUL) begin
            if (name_len == 0 || cont_left != 2'd0 || name_broken) begin
                st = unv_pkg::ST_BAD;
            end else if (first_fault != unv_pkg::ST_OK) begin
                st = first_fault;
            end else if (trailing_space) begin
                st = unv_pkg::ST_BAD;
            end
            clear_name_state();
            return 1'b1;
        end
        over = (name_len >= NAME_LIMIT);
        if (!over) begin
            name_len = name_len + 1;
        end
        if (b == CH_SLASH || (classic_mode && !in_classic_set(b))) begin
            name_broken = 1'b1;
        end
        used = 1'b0;
        if (cont_left != 2'd0) begin
            lo = 8'h80;
            hi = 8'hBF;
            case (cont_range)
                unv_pkg::LC_E0: lo = 8'hA0;
                unv_pkg::LC_ED: hi = 8'h9F;
                unv_pkg::LC_F0: lo = 8'h90;
                unv_pkg::LC_F4: hi = 8'h8F;
                default: ;
            endcase
            if (b >= lo && b <= hi) begin
                cont_left = cont_left - 2'd1;
                used = 1'b1;
            end else begin
                // The byte that broke the sequence is scanned again as a new character.
                name_broken = 1'b1;
                cont_left = 2'd0;
            end
            cont_range = unv_pkg::LC_ANY;
        end
        if (!used) begin
            plain = (b <= 8'h7F);
            if (!plain) begin
                if (b >= 8'hC2 && b <= 8'hDF) begin
                    cont_left = 2'd1;
                end else if (b == 8'hE0) begin
                    cont_left = 2'd2;
                    cont_range = unv_pkg::LC_E0;
                end else if (b == 8'hED) begin
                    cont_left = 2'd2;
                    cont_range = unv_pkg::LC_ED;
                end else if (b >= 8'hE1 && b <= 8'hEF) begin
                    cont_left = 2'd2;
                end else if (b == 8'hF0) begin
                    cont_left = 2'd3;
                    cont_range = unv_pkg::LC_F0;
                end else if (b >= 8'hF1 && b <= 8'hF3) begin
                    cont_left = 2'd3;
                end else if (b == 8'hF4) begin
                    cont_left = 2'd3;
                    cont_range = unv_pkg::LC_F4;
                end else begin
                    name_broken = 1'b1;
                end
            end
            if (!classic_mode && plain) begin
                if (first_pending) begin
                    if (!(is_alnum(b) || b == CH_UNDER)) begin
                        note_fault(unv_pkg::ST_BAD);
                    end
                end else if (b < CH_SPACE || b > 8'h7E) begin
                    note_fault(unv_pkg::ST_BAD);
                end
            end
            trailing_space = (b == CH_SPACE);
            first_pending = 1'b0;
        end
        if (over) begin
            note_fault(unv_pkg::ST_LONG);
        end
        return 1'b0;
    endfunction

    function automatic logic [7:0] pick_alnum();
        int k;
        k = $urandom_range(61);
        if (k < 26) begin
            return 8'(8'h41 + k);
        end else if (k < 52) begin
            return 8'(8'h61 + k - 26);
        end
        return 8'(8'h30 + k - 52);
    endfunction

    function automatic logic [7:0] pick_punct();
        int k;
        k = $urandom_range(7);
        return PUNCT[8*k +: 8];
    endfunction

    task automatic send_byte(input logic [7:0] b, input int want);
        logic [1:0] st;
        while (!calm && $urandom_range(99) < 9) begin
            i_push <= 1'b0;
            @(posedge i_clk);
        end
        i_push <= 1'b1;
        i_byte_value <= b;
        @(posedge i_clk);
        while (o_full) @(posedge i_clk);
        if (scan_name_byte(b, st)) begin
            status_due.push_back((want == FROM_MODEL) ? st : want[1:0]);
        end
        bytes_sent++;
    endtask

    // The rule set is changed only once every byte sent so far has been consumed.
    task automatic set_rule_set(input bit classic);
        i_push <= 1'b0;
        @(posedge i_clk);
        while (status_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= classic;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        classic_mode = classic;
        mode_writes++;
    endtask

    task automatic send_row(input t_name_row row);
        int k;
        if (row.mode != classic_mode) begin
            set_rule_set(row.mode);
        end
        for (k = 0; k < row.fill; k++) begin
            send_byte(CH_A, FROM_MODEL);
        end
        for (k = 0; k < row.nb; k++) begin
            send_byte(row.seq[8*(row.nb-1-k) +: 8], FROM_MODEL);
        end
        if (row.term) begin
            send_byte(CH_NUL, row.want);
        end
    endtask

    task automatic send_multibyte();
        int n;
        int k;
        logic [7:0] lead;
        logic [7:0] lo;
        logic [7:0] hi;
        n = $urandom_range(1, 3);
        case (n)
            1: lead = 8'($urandom_range(8'hC2, 8'hDF));
            2: case ($urandom_range(3))
                0: lead = 8'hE0;
                1: lead = 8'hED;
                default: lead = 8'($urandom_range(8'hE0, 8'hEF));
            endcase
            default: case ($urandom_range(3))
                0: lead = 8'hF0;
                1: lead = 8'hF4;
                default: lead = 8'($urandom_range(8'hF0, 8'hF4));
            endcase
        endcase
        lo = (lead == 8'hE0) ? 8'hA0 : (lead == 8'hF0) ? 8'h90 : 8'h80;
        hi = (lead == 8'hED) ? 8'h9F : (lead == 8'hF4) ? 8'h8F : 8'hBF;
        send_byte(lead, FROM_MODEL);
        for (k = 0; k < n; k++) begin
            if (k == 0 && $urandom_range(9) == 0) begin
                // Broken sequence: a byte that may not be a continuation.
                send_byte(8'($urandom_range(1, 255)), FROM_MODEL);
            end else begin
                send_byte(8'($urandom_range(lo, hi)), FROM_MODEL);
            end
            lo = 8'h80;
            hi = 8'hBF;
        end
    endtask

    task automatic send_char(input bit lead);
        int r;
        r = $urandom_range(99);
        if (classic_mode && r < 85) begin
            send_byte(($urandom_range(4) == 0) ? pick_punct() : pick_alnum(), FROM_MODEL);
        end else if (lead && r < 60) begin
            send_byte(pick_alnum(), FROM_MODEL);
        end else begin
            r = $urandom_range(99);
            if (r < 45) begin
                send_byte(pick_alnum(), FROM_MODEL);
            end else if (r < 52) begin
                send_byte(pick_punct(), FROM_MODEL);
            end else if (r < 62) begin
                send_byte(8'($urandom_range(8'h20, 8'h7E)), FROM_MODEL);
            end else if (r < 66) begin
                send_byte(CH_SPACE, FROM_MODEL);
            end else if (r < 69) begin
                send_byte(($urandom_range(3) == 0) ? CH_DEL : 8'($urandom_range(1, 8'h1F)),
                          FROM_MODEL);
            end else if (r < 88) begin
                send_multibyte();
            end else if (r < 94) begin
                // A lone byte from the upper half: stray continuation or tail-less lead.
                send_byte(8'($urandom_range(8'h80, 8'hFF)), FROM_MODEL);
            end else begin
                send_byte(8'($urandom_range(1, 255)), FROM_MODEL);
            end
        end
    endtask

    task automatic send_name(input bit open_end);
        int n;
        int k;
        if (long_names < 1 && $urandom_range(99) < 2) begin
            long_names++;
            n = $urandom_range(NAME_LIMIT - 6, NAME_LIMIT + 6);
            for (k = 0; k < n - 1; k++) begin
                send_byte(pick_alnum(), FROM_MODEL);
            end
            send_char(1'b0);
        end else begin
            n = ($urandom_range(99) < 5) ? 0 : $urandom_range(1, 12);
            if (open_end) begin
                n = $urandom_range(1, 3);
            end
            for (k = 0; k < n; k++) begin
                send_char(k == 0);
            end
        end
        if (!open_end) begin
            send_byte(CH_NUL, FROM_MODEL);
        end
    endtask

    // Status checker and result-side stall generator.
    always @(posedge i_clk) begin
        if (i_rst_n && i_pop && !o_empty) begin
            beats_seen++;
            if (status_due.size() == 0) begin
                $error("status beat %0d arrived with nothing expected", o_status);
                failures++;
            end else begin
                status_want = status_due.pop_front();
                if (o_status !== status_want) begin
                    $error("status: expected %0d, actual %0d", status_want, o_status);
                    failures++;
                end
            end
        end
        i_pop <= calm || ($urandom_range(99) >= 9);
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d status beats still due",
                     cycles, status_due.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        int base;
        int names_left;
        classic_mode = 1'b0;
        clear_name_state();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        set_rule_set(1'b0);

        foreach (directed_names[r]) begin
            send_row(directed_names[r]);
        end
        foreach (split_tail[r]) begin
            send_row(split_tail[r]);
        end

        base = bytes_sent;
        while (bytes_sent - base < RANDOM_BYTES) begin
            names_left = $urandom_range(8, 20);
            while (names_left > 0 && bytes_sent - base < RANDOM_BYTES) begin
                calm = (bytes_sent - base >= 100) && (bytes_sent - base < 220);
                send_name(1'b0);
                names_left--;
            end
            // Sometimes switch the rule set in the middle of a name.
            if ($urandom_range(3) == 0) begin
                send_name(1'b1);
            end
            set_rule_set(($urandom_range(3) == 0) ? classic_mode : !classic_mode);
        end
        calm = 1'b0;
        send_name(1'b0);

        i_push <= 1'b0;
        while (status_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Checked %0d status beats over %0d name bytes, %0d rule-set writes.",
                 beats_seen, bytes_sent, mode_writes);
        $display("Names near the length limit in the random part: %0d.", long_names);
        if (failures == 0 && status_due.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
